// File: src/wsat_pkg.sv
// Shared types and constants for the windowed stability auto-tare block.
package wsat_pkg;

  localparam int NET_W    = 24;
  localparam int TIME_W   = 32;
  localparam int WIN_W    = 16;
  localparam int TOL_W    = 16;
  localparam int THR_W    = 20;
  localparam int CFG_W    = 20;
  localparam int CFG_IW   = 2;

  localparam int SAMPLE_DEPTH_DEF = 128;

  localparam logic [WIN_W-1:0] WINDOW_RST    = WIN_W'(3000);
  localparam logic [TOL_W-1:0] TOLERANCE_RST = TOL_W'(200);
  localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(5000);

  localparam logic signed [NET_W-1:0] NET_MAX = 24'sh7FFFFF;
  localparam logic signed [NET_W-1:0] NET_MIN = 24'sh800000;

  // register indexes on the configuration port
  localparam logic [CFG_IW-1:0] CFG_WINDOW    = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_TOLERANCE = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_THRESHOLD = 2'd2;

  // item commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TARE   = 1'b1;

  typedef struct packed {
    logic                    cmd;
    logic signed [NET_W-1:0] raw_weight;
    logic [TIME_W-1:0]       time_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [NET_W-1:0] net_weight;
    logic [NET_W-1:0]        spread;
    logic                    is_stable;
    logic                    tared;
    logic signed [NET_W-1:0] tare_value;
  } out_item_t;

  typedef struct packed {
    logic signed [NET_W-1:0] weight;
    logic [TIME_W-1:0]       stamp;
  } sample_t;

  // verdict of the end-of-walk evaluation
  typedef struct packed {
    logic [NET_W-1:0]  spread;
    logic              stable;
    logic              tare;
    logic [TIME_W-1:0] stable_start_next;
  } eval_t;

endpackage

// File: src/wsat_store.sv
// Sample store: one write port, one read port, registered read data.
module wsat_store #(
  parameter int DEPTH = wsat_pkg::SAMPLE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  wsat_pkg::sample_t  wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output wsat_pkg::sample_t  rdata
);
  import wsat_pkg::*;

  sample_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/wsat_eval.sv
// End-of-walk evaluation: spread, stability and auto-tare decision.
module wsat_eval #(
  parameter int CW = 8
) (
  input  logic [CW-1:0]                      kept,
  input  logic signed [wsat_pkg::NET_W-1:0]  lo,
  input  logic signed [wsat_pkg::NET_W-1:0]  hi,
  input  logic [wsat_pkg::TIME_W-1:0]        now,
  input  logic [wsat_pkg::TIME_W-1:0]        stable_start,
  input  logic [wsat_pkg::WIN_W-1:0]         window_ms,
  input  logic [wsat_pkg::TOL_W-1:0]         spread_tolerance,
  input  logic [wsat_pkg::THR_W-1:0]         tare_threshold,
  input  logic signed [wsat_pkg::NET_W-1:0]  net,
  input  logic signed [wsat_pkg::NET_W-1:0]  weight_at_tare,
  output wsat_pkg::eval_t                    verdict
);
  import wsat_pkg::*;

  logic signed [NET_W:0] range_wide;
  logic [NET_W-1:0]      spread;
  logic [TIME_W-1:0]     start_eff;
  logic [TIME_W-1:0]     elapsed;
  logic signed [NET_W:0] dev;
  logic [NET_W:0]        dev_mag;
  logic                  close;

  assign range_wide = {hi[NET_W-1], hi} - {lo[NET_W-1], lo};
  always_comb begin
    if (kept == '0) begin
      spread = '0;
    end else if (range_wide[NET_W]) begin
      spread = '1;
    end else begin
      spread = range_wide[NET_W-1:0];
    end
  end

  // a zero start means not yet stable: stability begins now
  assign start_eff = (stable_start == '0) ? now : stable_start;
  assign elapsed   = now - start_eff;

  assign dev     = {net[NET_W-1], net} - {weight_at_tare[NET_W-1], weight_at_tare};
  assign dev_mag = dev[NET_W] ? (NET_W+1)'(-dev) : (NET_W+1)'(dev);
  assign close   = dev_mag < (NET_W+1)'(tare_threshold);

  always_comb begin
    verdict.spread            = spread;
    verdict.stable            = 1'b0;
    verdict.tare              = 1'b0;
    verdict.stable_start_next = '0;
    if (kept >= CW'(2) && spread <= NET_W'(spread_tolerance)) begin
      verdict.stable = 1'b1;
      if (elapsed >= TIME_W'(window_ms) && close) begin
        verdict.tare = 1'b1;
      end else begin
        verdict.stable_start_next = start_eff;
      end
    end
  end

endmodule

// File: src/windowed_stability_auto_tare.sv
// Top level of the windowed stability auto-tare block.
//
// Input channel (in_valid/in_ready/in_data) takes one item: a weight sample
// (cmd = CMD_SAMPLE) or a manual tare (cmd = CMD_TARE). Each item yields
// exactly one result item on the output channel (out_valid/out_ready/out_data).
//
// Items are handled one at a time. A sample item is appended to the store and
// then walks over every sample held there (at most SAMPLE_DEPTH), one entry
// read per cycle through its single read port, pruning stale entries and
// tracking min/max in the same pass; the verdict follows the walk. A manual
// tare goes straight to its result. in_ready is high only while idle.
//
// The result sits in an output register; a new item is taken while it waits.
// If the receiver stalls, the next item finishes its walk and then holds in
// its final step until the output register is free.
//
// Reset (rst, synchronous) empties the store by clearing the fill count,
// zeroes tare and history, and loads the default window, tolerance and
// threshold. No clearing pass is needed. Config writes are taken at any time
// but are meant for idle periods only.
module windowed_stability_auto_tare #(
  parameter int SAMPLE_DEPTH = wsat_pkg::SAMPLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [wsat_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [wsat_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  wsat_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output wsat_pkg::out_item_t           out_data
);
  import wsat_pkg::*;

  localparam int AW = $clog2(SAMPLE_DEPTH);
  localparam int CW = $clog2(SAMPLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_APPEND = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_EVAL   = 3'd3;
  localparam logic [2:0] S_MANUAL = 3'd4;

  logic [2:0] state;

  // configuration registers
  logic [WIN_W-1:0] window_ms;
  logic [TOL_W-1:0] spread_tolerance;
  logic [THR_W-1:0] tare_threshold;

  // block state
  logic [CW-1:0]           sample_count;
  logic [TIME_W-1:0]       stable_start;
  logic signed [NET_W-1:0] tare_offset;
  logic signed [NET_W-1:0] weight_at_tare;
  logic signed [NET_W-1:0] last_raw;
  logic signed [NET_W-1:0] last_net;

  // working registers for the current item
  in_item_t                item;
  logic [CW-1:0]           rd_idx;
  logic [CW-1:0]           kept;
  logic                    rd_pending;
  logic signed [NET_W-1:0] lo;
  logic signed [NET_W-1:0] hi;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  sample_t                 mem_wdata;
  logic                    mem_re;
  logic [AW-1:0]           mem_raddr;
  sample_t                 mem_rdata;

  logic signed [NET_W:0]   net_wide;
  logic signed [NET_W-1:0] net_sat;
  logic                    store_full;
  logic                    keep;
  logic                    out_free;
  logic                    out_load;
  eval_t                   verdict;

  // raw minus tare, saturated to 24 bits
  assign net_wide = {item.raw_weight[NET_W-1], item.raw_weight}
                  - {tare_offset[NET_W-1], tare_offset};
  always_comb begin
    if (net_wide[NET_W] != net_wide[NET_W-1]) begin
      net_sat = net_wide[NET_W] ? NET_MIN : NET_MAX;
    end else begin
      net_sat = net_wide[NET_W-1:0];
    end
  end

  assign store_full = (sample_count >= CW'(SAMPLE_DEPTH));
  // entry survives if its age (mod 2^32) is within the window
  assign keep       = (item.time_ms - mem_rdata.stamp) <= TIME_W'(window_ms);
  assign out_free   = !out_valid || out_ready;
  // a result is loaded into the output register this cycle
  assign out_load   = ((state == S_EVAL) || (state == S_MANUAL)) && out_free;
  assign in_ready   = (state == S_IDLE);

  // store port control: append write, then compacting writes during the walk.
  // A compacting write goes to kept <= entry read, so it never hits a later read.
  always_comb begin
    mem_re    = (state == S_WALK) && (rd_idx < sample_count);
    mem_raddr = rd_idx[AW-1:0];
    if (state == S_APPEND) begin
      mem_we           = !store_full;
      mem_waddr        = sample_count[AW-1:0];
      mem_wdata.weight = net_sat;
      mem_wdata.stamp  = item.time_ms;
    end else begin
      mem_we    = (state == S_WALK) && rd_pending && keep;
      mem_waddr = kept[AW-1:0];
      mem_wdata = mem_rdata;
    end
  end

  wsat_store #(
    .DEPTH (SAMPLE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  wsat_eval #(
    .CW (CW)
  ) u_eval (
    .kept             (kept),
    .lo               (lo),
    .hi               (hi),
    .now              (item.time_ms),
    .stable_start     (stable_start),
    .window_ms        (window_ms),
    .spread_tolerance (spread_tolerance),
    .tare_threshold   (tare_threshold),
    .net              (last_net),
    .weight_at_tare   (weight_at_tare),
    .verdict          (verdict)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms        <= WINDOW_RST;
      spread_tolerance <= TOLERANCE_RST;
      tare_threshold   <= THRESHOLD_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WINDOW:    window_ms        <= cfg_data[WIN_W-1:0];
        CFG_TOLERANCE: spread_tolerance <= cfg_data[TOL_W-1:0];
        CFG_THRESHOLD: tare_threshold   <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      sample_count   <= '0;
      stable_start   <= '0;
      tare_offset    <= '0;
      weight_at_tare <= '0;
      last_raw       <= '0;
      last_net       <= '0;
      rd_pending     <= 1'b0;
      rd_idx         <= '0;
      kept           <= '0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            state <= (in_data.cmd == CMD_TARE) ? S_MANUAL : S_APPEND;
          end
        end
        S_APPEND: begin
          last_raw   <= item.raw_weight;
          last_net   <= net_sat;
          if (!store_full) begin
            sample_count <= sample_count + CW'(1);
          end
          rd_idx     <= '0;
          kept       <= '0;
          rd_pending <= 1'b0;
          state      <= S_WALK;
        end
        S_WALK: begin
          rd_pending <= mem_re;
          if (mem_re) begin
            rd_idx <= rd_idx + CW'(1);
          end
          if (rd_pending && keep) begin
            kept <= kept + CW'(1);
            if (kept == '0) begin
              lo <= mem_rdata.weight;
              hi <= mem_rdata.weight;
            end else begin
              if (mem_rdata.weight < lo) lo <= mem_rdata.weight;
              if (mem_rdata.weight > hi) hi <= mem_rdata.weight;
            end
          end
          if (!mem_re && !rd_pending) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (out_free) begin
            out_valid           <= 1'b1;
            out_data.net_weight <= last_net;
            out_data.spread     <= verdict.spread;
            out_data.is_stable  <= verdict.stable;
            out_data.tared      <= verdict.tare;
            out_data.tare_value <= verdict.tare ? last_raw : tare_offset;
            stable_start        <= verdict.stable_start_next;
            if (verdict.tare) begin
              sample_count   <= '0;
              tare_offset    <= last_raw;
              weight_at_tare <= last_net;
            end else begin
              sample_count <= kept;
            end
            state <= S_IDLE;
          end
        end
        S_MANUAL: begin
          if (out_free) begin
            out_valid           <= 1'b1;
            out_data.net_weight <= last_net;
            out_data.spread     <= '0;
            out_data.is_stable  <= 1'b0;
            out_data.tared      <= 1'b1;
            out_data.tare_value <= last_raw;
            tare_offset         <= last_raw;
            weight_at_tare      <= last_net;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/wsat_checker.sv
// Port-level checks for the auto-tare block, bound to the top level.
module wsat_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input wsat_pkg::out_item_t           out_data
);
  import wsat_pkg::*;

  // one item in flight: ready drops straight after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while an item is in flight");

  // a tare without stability can only be a manual one, which reports no spread
  a_manual_tare_spread: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.tared && !out_data.is_stable |-> out_data.spread == '0)
    else $error("manual tare result carries a spread");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item changed or dropped while stalled");

  // no result straight out of reset
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind windowed_stability_auto_tare wsat_checker u_wsat_checker (.*);
